### rtl/core/fmcq_pkg.sv
// Shared types, codes and pointer helpers for the lock unit with condition queue.
`timescale 1ns / 1ps

package fmcq_pkg;

  localparam int NUM_REQUESTERS = 16;
  localparam int QUEUE_DEPTH    = 16;

  localparam int ID_W  = $clog2(NUM_REQUESTERS);
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [2:0] {
    MODE_LOCK              = 3'd0,
    MODE_UNLOCK            = 3'd1,
    MODE_UNLOCK_IF_WAITERS = 3'd2,
    MODE_COND_WAIT         = 3'd3,
    MODE_COND_SIGNAL       = 3'd4,
    MODE_COND_BROADCAST    = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_BLOCKED   = 2'd1,
    ST_NOT_OWNER = 2'd2,
    ST_REFUSED   = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]      mode;
    logic [ID_W-1:0] requester;
  } in_item_t;

  typedef struct packed {
    status_e         status;
    logic            released;
    logic            woken_valid;
    logic [ID_W-1:0] woken_id;
    logic            owner_valid;
    logic [ID_W-1:0] owner_id;
  } out_item_t;

  // One queue memory port set: a write and a read address each cycle.
  typedef struct packed {
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [ID_W-1:0]  wr_data;
    logic [PTR_W-1:0] rd_addr;
  } qmem_req_t;

  // Handshake status from the sequencer to the top level.
  typedef struct packed {
    logic idle;
    logic done;
  } ctrl_stat_t;

  // Circular slot: head plus an offset, wrapped at the queue depth.
  function automatic logic [PTR_W-1:0] slot_add(logic [PTR_W-1:0] head,
                                                 logic [CNT_W-1:0] offs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(offs);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

### rtl/core/fmcq_qmem.sv
// Queue storage: one write port and one registered read port.
`timescale 1ns / 1ps

module fmcq_qmem (
  input  logic                       clk_i,
  input  fmcq_pkg::qmem_req_t        req_i,
  output logic [fmcq_pkg::ID_W-1:0]  rd_data_o
);
  import fmcq_pkg::*;

  logic [ID_W-1:0] mem_q [QUEUE_DEPTH];
  logic [ID_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    rd_data_q <= mem_q[req_i.rd_addr];
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/fmcq_ctrl.sv
// Sequencer: mutex state, queue pointers, membership flags and per-request update.
`timescale 1ns / 1ps

module fmcq_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  fmcq_pkg::in_item_t         item_i,
  input  logic [fmcq_pkg::ID_W-1:0]  lq_rd_i,
  input  logic [fmcq_pkg::ID_W-1:0]  cq_rd_i,
  output fmcq_pkg::qmem_req_t        lq_req_o,
  output fmcq_pkg::qmem_req_t        cq_req_o,
  output fmcq_pkg::ctrl_stat_t       stat_o,
  output fmcq_pkg::out_item_t        result_o
);
  import fmcq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                      state_q, state_d;
  logic [2:0]                mode_q, mode_d;
  logic [ID_W-1:0]           req_q, req_d;
  logic                      held_q, held_d;
  logic [ID_W-1:0]           holder_q, holder_d;
  logic [PTR_W-1:0]          lhead_q, lhead_d;
  logic [CNT_W-1:0]          lcount_q, lcount_d;
  logic [PTR_W-1:0]          chead_q, chead_d;
  logic [CNT_W-1:0]          ccount_q, ccount_d;
  logic [NUM_REQUESTERS-1:0] in_lq_q, in_lq_d;
  logic [NUM_REQUESTERS-1:0] in_cq_q, in_cq_d;
  logic                      wv_q, wv_d;
  logic [ID_W-1:0]           wid_q, wid_d;

  logic      is_owner;
  logic      mv_fail;
  logic      do_release;
  logic      done;
  status_e   res_status;
  logic      res_rel;
  qmem_req_t lq_req;
  qmem_req_t cq_req;

  assign is_owner = held_q && (holder_q == req_q);
  // Oldest condition waiter cannot move: owner, already queued, or no room.
  assign mv_fail  = (held_q && (holder_q == cq_rd_i)) || in_lq_q[cq_rd_i] ||
                    (held_q && (lcount_q >= CNT_W'(QUEUE_DEPTH)));

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    req_d      = req_q;
    held_d     = held_q;
    holder_d   = holder_q;
    lhead_d    = lhead_q;
    lcount_d   = lcount_q;
    chead_d    = chead_q;
    ccount_d   = ccount_q;
    in_lq_d    = in_lq_q;
    in_cq_d    = in_cq_q;
    wv_d       = wv_q;
    wid_d      = wid_q;
    do_release = 1'b0;
    done       = 1'b0;
    res_status = ST_DONE;
    res_rel    = 1'b0;

    lq_req         = '0;
    lq_req.wr_addr = slot_add(lhead_q, lcount_q);
    lq_req.wr_data = req_q;
    cq_req         = '0;
    cq_req.wr_addr = slot_add(chead_q, ccount_q);
    cq_req.wr_data = req_q;

    if (state_q == S_IDLE) begin
      if (start_i) begin
        mode_d  = item_i.mode;
        req_d   = item_i.requester;
        wv_d    = 1'b0;
        wid_d   = '0;
        state_d = S_EXEC;
      end
    end else begin
      done    = 1'b1;
      state_d = S_IDLE;
      case (mode_q)
        MODE_LOCK: begin
          if (is_owner || in_lq_q[req_q]) begin
            res_status = ST_REFUSED;
          end else if (!held_q) begin
            held_d   = 1'b1;
            holder_d = req_q;
          end else if (lcount_q >= CNT_W'(QUEUE_DEPTH)) begin
            res_status = ST_REFUSED;
          end else begin
            lq_req.wr_en   = 1'b1;
            lcount_d       = lcount_q + CNT_W'(1);
            in_lq_d[req_q] = 1'b1;
            res_status     = ST_BLOCKED;
          end
        end
        MODE_UNLOCK, MODE_UNLOCK_IF_WAITERS: begin
          if (!is_owner) begin
            res_status = ST_NOT_OWNER;
          end else if ((mode_q == MODE_UNLOCK) || (lcount_q != '0)) begin
            res_rel    = 1'b1;
            do_release = 1'b1;
          end
        end
        MODE_COND_WAIT: begin
          if (!is_owner) begin
            res_status = ST_NOT_OWNER;
          end else if ((ccount_q >= CNT_W'(QUEUE_DEPTH)) || in_cq_q[req_q]) begin
            res_status = ST_REFUSED;
          end else begin
            cq_req.wr_en   = 1'b1;
            ccount_d       = ccount_q + CNT_W'(1);
            in_cq_d[req_q] = 1'b1;
            res_rel        = 1'b1;
            do_release     = 1'b1;
            res_status     = ST_BLOCKED;
          end
        end
        MODE_COND_SIGNAL, MODE_COND_BROADCAST: begin
          if (ccount_q != '0) begin
            if (mv_fail) begin
              res_status = ST_REFUSED;
            end else begin
              chead_d          = slot_add(chead_q, CNT_W'(1));
              ccount_d         = ccount_q - CNT_W'(1);
              in_cq_d[cq_rd_i] = 1'b0;
              if (!held_q) begin
                held_d   = 1'b1;
                holder_d = cq_rd_i;
                wv_d     = 1'b1;
                wid_d    = cq_rd_i;
              end else begin
                lq_req.wr_en     = 1'b1;
                lq_req.wr_data   = cq_rd_i;
                lcount_d         = lcount_q + CNT_W'(1);
                in_lq_d[cq_rd_i] = 1'b1;
              end
              // Broadcast: stay on while waiters remain, one per cycle.
              if ((mode_q == MODE_COND_BROADCAST) && (ccount_q > CNT_W'(1))) begin
                done    = 1'b0;
                state_d = S_EXEC;
              end
            end
          end
        end
        default: begin
        end
      endcase

      // Hand the mutex to the oldest waiter, or free it.
      if (do_release) begin
        if (lcount_q != '0) begin
          holder_d         = lq_rd_i;
          lhead_d          = slot_add(lhead_q, CNT_W'(1));
          lcount_d         = lcount_q - CNT_W'(1);
          in_lq_d[lq_rd_i] = 1'b0;
          wv_d             = 1'b1;
          wid_d            = lq_rd_i;
        end else begin
          held_d   = 1'b0;
          holder_d = '0;
        end
      end
    end

    // Read the head that will stand after this edge.
    lq_req.rd_addr = lhead_d;
    cq_req.rd_addr = chead_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mode_q   <= '0;
      req_q    <= '0;
      held_q   <= 1'b0;
      holder_q <= '0;
      lhead_q  <= '0;
      lcount_q <= '0;
      chead_q  <= '0;
      ccount_q <= '0;
      in_lq_q  <= '0;
      in_cq_q  <= '0;
      wv_q     <= 1'b0;
      wid_q    <= '0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      req_q    <= req_d;
      held_q   <= held_d;
      holder_q <= holder_d;
      lhead_q  <= lhead_d;
      lcount_q <= lcount_d;
      chead_q  <= chead_d;
      ccount_q <= ccount_d;
      in_lq_q  <= in_lq_d;
      in_cq_q  <= in_cq_d;
      wv_q     <= wv_d;
      wid_q    <= wid_d;
    end
  end

  assign lq_req_o = lq_req;
  assign cq_req_o = cq_req;

  assign stat_o.idle = (state_q == S_IDLE);
  assign stat_o.done = done;

  assign result_o.status      = res_status;
  assign result_o.released    = res_rel;
  assign result_o.woken_valid = wv_d;
  assign result_o.woken_id    = wv_d ? wid_d : '0;
  assign result_o.owner_valid = held_d;
  assign result_o.owner_id    = held_d ? holder_d : '0;

`ifndef NO_ASSERTIONS
  a_lq_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(in_lq_q) == int'(lcount_q))
    else $error("lock queue flags disagree with fill count");

  a_cq_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(in_cq_q) == int'(ccount_q))
    else $error("condition queue flags disagree with fill count");

  a_free_holder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !held_q |-> (holder_q == '0))
    else $error("free mutex carries a holder");

  a_no_wait_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !held_q |-> (lcount_q == '0))
    else $error("waiters queued on a free mutex");
`endif

endmodule

### rtl/core/fifo_mutex_with_condition_queue_top.sv
// Top level of the lock unit: queue memories, sequencer and result register.
`timescale 1ns / 1ps
// Flow: a request is accepted, worked in the next cycle and its result is
//   registered at the end of that cycle; a broadcast stays in the work state
//   while it moves its waiters one after another. A new request is taken only
//   once the sequencer is idle again and the result register is free.
// Reset: clears the mutex, queue pointers, fill counts and membership flags;
//   queue memory contents are left as they are, since only live entries are read.

module fifo_mutex_with_condition_queue_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fmcq_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fmcq_pkg::out_item_t out_data_o
);
  import fmcq_pkg::*;

  logic            start;
  qmem_req_t       lq_req;
  qmem_req_t       cq_req;
  logic [ID_W-1:0] lq_rd;
  logic [ID_W-1:0] cq_rd;
  ctrl_stat_t      stat;
  out_item_t       result;

  logic      out_valid_q;
  out_item_t out_data_q;

  // Take a new request only when the sequencer is idle and the result
  // register is empty or its transfer completes at this edge.
  assign in_ready_o = stat.idle && (!out_valid_q || out_ready_i);
  assign start      = in_valid_i && in_ready_o;

  // Mutex waiter queue.
  fmcq_qmem u_lock_mem (
    .clk_i     (clk_i),
    .req_i     (lq_req),
    .rd_data_o (lq_rd)
  );

  // Condition waiter queue.
  fmcq_qmem u_cond_mem (
    .clk_i     (clk_i),
    .req_i     (cq_req),
    .rd_data_o (cq_rd)
  );

  fmcq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .item_i   (in_data_i),
    .lq_rd_i  (lq_rd),
    .cq_rd_i  (cq_rd),
    .lq_req_o (lq_req),
    .cq_req_o (cq_req),
    .stat_o   (stat),
    .result_o (result)
  );

  // Result register: load on completion, drop once the transfer is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.done) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_done_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |-> !out_valid_q)
    else $error("result completed while the result register is occupied");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !stat.idle)
    else $error("accepted request did not enter the sequencer");
`endif

endmodule
